// ===== design/scalar_to_rgb_colormap_unit_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef SCALAR_TO_RGB_COLORMAP_UNIT_MACROS_SVH
`define SCALAR_TO_RGB_COLORMAP_UNIT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define S2C_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define S2C_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/s2c_pkg.sv =====
package s2c_pkg;

  typedef enum logic [1:0] {
    MAP_VIRIDIS = 2'd0,
    MAP_RAMP    = 2'd1,
    MAP_GREY    = 2'd2
  } map_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Viridis stops in thousandths, one row per stop: red, green, blue.
  localparam logic [9:0] STOP_TAB [0:8][0:2] = '{
    '{10'd267, 10'd5,   10'd329},
    '{10'd283, 10'd141, 10'd458},
    '{10'd254, 10'd265, 10'd530},
    '{10'd207, 10'd372, 10'd553},
    '{10'd164, 10'd471, 10'd558},
    '{10'd128, 10'd567, 10'd551},
    '{10'd135, 10'd659, 10'd518},
    '{10'd267, 10'd749, 10'd441},
    '{10'd478, 10'd821, 10'd318}
  };

  // Yellow end point in thousandths, already scaled by 255.
  localparam logic [17:0] PEAK_255 [0:2] = '{18'd253215, 18'd231030, 18'd36720};

  // floor(y / 1000) == (y * RECIP_1000) >> RECIP_SHIFT for every y below 2^18.
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  localparam int          ROUND_K    = 500;
  localparam logic [9:0]  SCALE_K    = 10'd1000;
  localparam logic [9:0]  GREY_SLOPE = 10'd867;
  localparam int          GREY_BIAS  = 104;
  localparam logic [4:0]  BLEND_MUL  = 5'd20;
  localparam int          BLEND_LIM  = 19;

endpackage

// ===== design/s2c_fifo.sv =====
module s2c_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/s2c_front.sv =====
module s2c_front import s2c_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  localparam int CW = FRACTION_BITS + 1,
  localparam int JW = 3 * CW + 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  input  logic [CW-1:0] scalar_level_i,
  output logic [JW-1:0] job_o
);

  localparam int F = FRACTION_BITS;
  localparam logic [CW-1:0]  ONE       = {1'b1, {F{1'b0}}};
  localparam logic [CW+4:0]  BLEND_TOP = (CW + 5)'(BLEND_LIM) << F;

  typedef struct packed {
    logic [1:0]    map_sel;
    logic [CW-1:0] code;
    logic [2:0]    lower;
    logic [CW-1:0] frac;
    logic          blend;
    logic [CW-1:0] weight;
  } job_t;

  logic [1:0]    map_q;
  logic [CW-1:0] code_sat;
  logic [3:0]    lower_raw;
  logic [2:0]    lower;
  logic [CW+2:0] frac_w;
  logic [CW+4:0] code_x20;
  logic [CW+4:0] weight_w;
  job_t          job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MAP_VIRIDIS;
    end else if (cfg_we_i) begin
      map_q <= cfg_wdata_i;
    end
  end

  // Saturate, then split t into the viridis segment, its fraction and the
  // weight of the blend toward yellow near the top of the range.
  always_comb begin
    code_sat  = (scalar_level_i > ONE) ? ONE : scalar_level_i;
    lower_raw = 4'(code_sat >> (F - 3));
    lower     = (lower_raw > 4'd7) ? 3'd7 : lower_raw[2:0];
    frac_w    = {code_sat, 3'b000} - ((CW + 3)'(lower) << F);
    code_x20  = (CW + 5)'(code_sat) * BLEND_MUL;
    weight_w  = code_x20 - BLEND_TOP;

    job.map_sel = map_q;
    job.code    = code_sat;
    job.lower   = lower;
    job.frac    = frac_w[CW-1:0];
    job.blend   = (code_x20 > BLEND_TOP);
    job.weight  = weight_w[CW-1:0];
  end

  assign job_o = job;

endmodule

// ===== design/s2c_back.sv =====
module s2c_back import s2c_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  localparam int CW = FRACTION_BITS + 1,
  localparam int JW = 3 * CW + 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [JW-1:0] job_i,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output rgb_t          res_o
);

  localparam int F  = FRACTION_BITS;
  localparam int NW = F + 10;
  localparam int SW = F + 18;
  localparam int QW = 37;
  localparam int PW = F + 19;
  localparam logic [CW-1:0]  ONE         = {1'b1, {F{1'b0}}};
  localparam logic [F+2:0]   ONE_X       = (F + 3)'(1) << F;
  localparam logic [SW-1:0]  Y_BIAS      = SW'(ROUND_K) << F;
  localparam logic [NW-1:0]  GREY_OFFSET = NW'(GREY_BIAS) << F;
  localparam logic [F+8:0]   RAMP_HALF   = (F + 9)'(1) << (F - 1);

  typedef struct packed {
    logic [1:0]    map_sel;
    logic [CW-1:0] code;
    logic [2:0]    lower;
    logic [CW-1:0] frac;
    logic          blend;
    logic [CW-1:0] weight;
  } job_t;

  typedef struct packed {
    logic [1:0] map_sel;
    logic       blend;
  } side_t;

  job_t                 job;
  logic                 adv;
  logic [5:0]           vld_q;
  side_t                side_q [6];

  // Shared stage values.
  logic [NW-1:0]        omw_d, omw1_q, omw2_q, omw3_q;
  logic [CW-1:0]        w1_q, w2_q, w3_q;
  logic [NW-1:0]        grey_prod_d, grey_prod_q;
  logic [2:0][CW-1:0]   ramp_d, ramp_q;
  logic [2:0][7:0]      alt_d;
  logic [2:0][7:0]      alt_q [5];
  logic [1:0]           seg;
  logic [2:0]           seg_raw;
  logic [F+2:0]         x_val, rv, gv, bv;
  logic [NW-1:0]        grey_sum;
  logic [2:0][F+8:0]    ramp_sum;
  logic [2:0][7:0]      lane_res;

  assign job        = job_i;
  assign adv        = ~res_full_i;
  assign job_pop_o  = adv & job_valid_i;
  assign res_push_o = adv & vld_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:0], job_valid_i};
    end
  end

  // Stage one: ramp segment, grey slope and the blend complement.
  always_comb begin
    x_val   = {job.code, 2'b00};
    seg_raw = x_val[F+2:F];
    seg     = (seg_raw > 3'd3) ? 2'd3 : seg_raw[1:0];
    unique case (seg)
      2'd0: begin
        rv = '0;
        gv = x_val;
        bv = ONE_X;
      end
      2'd1: begin
        rv = '0;
        gv = ONE_X;
        bv = (ONE_X << 1) - x_val;
      end
      2'd2: begin
        rv = x_val - (ONE_X << 1);
        gv = ONE_X;
        bv = '0;
      end
      default: begin
        rv = ONE_X;
        gv = (ONE_X << 2) - x_val;
        bv = '0;
      end
    endcase
    ramp_d[0]   = rv[CW-1:0];
    ramp_d[1]   = gv[CW-1:0];
    ramp_d[2]   = bv[CW-1:0];
    omw_d       = (ONE - job.weight) * SCALE_K;
    grey_prod_d = job.code * GREY_SLOPE;
  end

  // Stage two: ramp and greyscale bytes need only a rounding shift.
  always_comb begin
    grey_sum = grey_prod_q + GREY_OFFSET;
    for (int k = 0; k < 3; k++) begin
      ramp_sum[k] = {ramp_q[k], 8'h00} - {8'h00, ramp_q[k]} + RAMP_HALF;
    end
    case (side_q[0].map_sel)
      MAP_RAMP: begin
        for (int k = 0; k < 3; k++) begin
          alt_d[k] = ramp_sum[k][F+7:F];
        end
      end
      MAP_GREY: begin
        for (int k = 0; k < 3; k++) begin
          alt_d[k] = grey_sum[F+9:F+2];
        end
      end
      default: alt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0]   <= '{map_sel: job.map_sel, blend: job.blend};
      for (int k = 1; k < 6; k++) begin
        side_q[k] <= side_q[k-1];
      end
      omw1_q      <= omw_d;
      omw2_q      <= omw1_q;
      omw3_q      <= omw2_q;
      w1_q        <= job.weight;
      w2_q        <= w1_q;
      w3_q        <= w2_q;
      grey_prod_q <= grey_prod_d;
      ramp_q      <= ramp_d;
      alt_q[0]    <= alt_d;
      for (int k = 1; k < 5; k++) begin
        alt_q[k]  <= alt_q[k-1];
      end
    end
  end

  // One lane per color channel: interpolate, divide by 1000 through a
  // reciprocal, then blend toward yellow and divide again.
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [9:0]           sa, sb;
    logic signed [10:0]   diff;
    logic signed [CW+11:0] prod, base, sum1;
    logic [NW-1:0]        n1_q;
    logic [SW-1:0]        sum2, sum5;
    logic [17:0]          y1_d, y1_q, y2_d, y2_q;
    logic [QW-1:0]        q1_q, q2_q;
    logic [7:0]           byte1, byte2;
    logic [7:0]           b4_q, b5_q, b6_q;
    logic [PW-1:0]        p1_q, p2_q, p_sum;

    always_comb begin
      sa    = STOP_TAB[job.lower][c];
      sb    = STOP_TAB[4'(job.lower) + 4'd1][c];
      diff  = $signed({1'b0, sb}) - $signed({1'b0, sa});
      prod  = diff * $signed({1'b0, job.frac});
      base  = $signed({3'b000, sa, {F{1'b0}}});
      sum1  = prod + base;
      sum2  = {n1_q, 8'h00} - {8'h00, n1_q} + Y_BIAS;
      y1_d  = sum2[SW-1:F];
      byte1 = q1_q[RECIP_SHIFT+7:RECIP_SHIFT];
      p_sum = p1_q + p2_q + PW'(Y_BIAS);
      sum5  = p_sum[SW-1:0];
      y2_d  = sum5[SW-1:F];
      byte2 = q2_q[RECIP_SHIFT+7:RECIP_SHIFT];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        n1_q <= sum1[NW-1:0];
        y1_q <= y1_d;
        q1_q <= y1_q * RECIP_1000;
        b4_q <= byte1;
        p1_q <= byte1 * omw3_q;
        p2_q <= PEAK_255[c] * w3_q;
        b5_q <= b4_q;
        y2_q <= y2_d;
        b6_q <= b5_q;
        q2_q <= y2_q * RECIP_1000;
      end
    end

    assign lane_res[c] = (side_q[5].map_sel != MAP_VIRIDIS) ? alt_q[4][c] :
                         side_q[5].blend ? byte2 : b6_q;
  end

  assign res_o.red   = lane_res[0];
  assign res_o.green = lane_res[1];
  assign res_o.blue  = lane_res[2];

endmodule

// ===== design/scalar_to_rgb_colormap_unit.sv =====
// Channel    Direction  Handshake           Payload
// input      in         push / full         scalar_level_i
// result     out        empty / pop         red_level_o, green_level_o, blue_level_o
// config     in         cfg_we_i            cfg_wdata_i (color map select)
//
// One scalar is taken every clock while full is low; a result passes the input
// queue, the six-stage back pipeline with its two reciprocal multiplies per
// channel and the result queue. Reset clears both queues, the pipeline valid bits
// and the map register (viridis); there is no clearing pass. The back pipeline
// holds while the two-entry result queue is full; the two-entry input queue
// then fills and raises full.
module scalar_to_rgb_colormap_unit import s2c_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [FRACTION_BITS:0]   scalar_level_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [7:0]               red_level_o,
  output logic [7:0]               green_level_o,
  output logic [7:0]               blue_level_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_wdata_i
);

  localparam int CW        = FRACTION_BITS + 1;
  localparam int JW        = 3 * CW + 6;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  logic [JW-1:0] job_in, job_out;
  logic          mid_empty, job_pop;
  logic          res_full, res_push;
  rgb_t          res_in, res_out;

  s2c_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .scalar_level_i (scalar_level_i),
    .job_o          (job_in)
  );

  s2c_fifo #(.WIDTH(JW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (mid_empty)
  );

  s2c_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (~mid_empty),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  s2c_fifo #(.WIDTH($bits(rgb_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign red_level_o   = res_out.red;
  assign green_level_o = res_out.green;
  assign blue_level_o  = res_out.blue;

endmodule

// ===== design/s2c_checker.sv =====
`include "scalar_to_rgb_colormap_unit_macros.svh"

module s2c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] red_level_o,
  input logic [7:0] green_level_o,
  input logic [7:0] blue_level_o
);

  // Both queues are empty on the edge after reset was seen.
  `S2C_ASSERT_ALWAYS(a_reset_state, clk_i, !rst_ni |=> (empty && !full), "queues not empty in reset")

  // Checks that full is raised only while a result waits to be taken.
  `S2C_ASSERT(a_full_needs_result, clk_i, rst_ni, full |-> !empty, "full while no result waits")

  // A waiting result is not withdrawn and does not change until taken.
  `S2C_ASSERT(a_result_kept, clk_i, rst_ni, (!empty && !pop) |=> !empty, "result withdrawn")
  `S2C_ASSERT(a_result_stable, clk_i, rst_ni, (!empty && !pop) |=> $stable({red_level_o, green_level_o, blue_level_o}), "result changed while waiting")

endmodule

bind scalar_to_rgb_colormap_unit s2c_checker u_s2c_checker (.*);
